[rtl/box_mesh_generator_unit_macros.svh]
// Assertion macros shared by the box mesh generator RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BOX_MESH_GENERATOR_UNIT_MACROS_SVH
`define BOX_MESH_GENERATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bmg_pkg.sv]
// Shared types and constants of the box mesh generator.
// No dependencies; used by every module of the block.
package bmg_pkg;

  localparam int SEG_W     = 8;
  localparam int CNT_W     = 9;
  localparam int BASE_W    = 19;
  localparam int FACE_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_SEGMENTS = 255;
  localparam int DEF_FRAC_BITS    = 16;

  localparam logic [FACE_W-1:0] LAST_FACE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_U = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_V = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_W = 2'd2;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  // One element as classified by the front end.
  typedef struct packed {
    logic              kind;
    logic [FACE_W-1:0] face;
    logic [CNT_W-1:0]  col;
    logic [CNT_W-1:0]  row;
    logic [SEG_W-1:0]  cols;
    logic [SEG_W-1:0]  rows;
    logic              half_quad;
    logic [BASE_W-1:0] base;
    logic              last;
  } item_t;

endpackage

[rtl/bmg_front.sv]
// Front end: configuration registers and the mesh walk sequencer.
// Depends on bmg_pkg and the assertion macros header.
`include "box_mesh_generator_unit_macros.svh"
module bmg_front #(
  parameter int MAX_SEGMENTS = bmg_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmg_pkg::SEG_W-1:0]      cfg_data,
  input  logic                           in_push,
  input  logic                           in_restart,
  input  logic                           q_full,
  output logic                           q_push,
  output bmg_pkg::item_t                 q_item
);
  import bmg_pkg::*;

  localparam int SEG_MAXV = (1 << SEG_W) - 1;
  localparam logic [SEG_W-1:0] SEG_CAP =
    SEG_W'((MAX_SEGMENTS > SEG_MAXV) ? SEG_MAXV : MAX_SEGMENTS);

  logic [SEG_W-1:0]  seg_u_r, seg_v_r, seg_w_r;
  logic [SEG_W-1:0]  seg_val;

  logic              phase_r, phase_nxt;
  logic              half_r, half_nxt;
  logic [FACE_W-1:0] face_r, face_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;

  logic              cur_phase, cur_half;
  logic [FACE_W-1:0] cur_face;
  logic [CNT_W-1:0]  cur_row, cur_col;
  logic [BASE_W-1:0] cur_base;
  logic [SEG_W-1:0]  cols, rows;
  logic [CNT_W-1:0]  clim, rlim, st, rt;
  logic [2*CNT_W-1:0] area;
  logic              wrap;

  always_comb begin
    seg_val = cfg_data;
    if (seg_val == '0) begin
      seg_val = SEG_W'(1);
    end else if (seg_val > SEG_CAP) begin
      seg_val = SEG_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_u_r <= SEG_W'(1);
      seg_v_r <= SEG_W'(1);
      seg_w_r <= SEG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEG_U: seg_u_r <= seg_val;
        CFG_SEG_V: seg_v_r <= seg_val;
        CFG_SEG_W: seg_w_r <= seg_val;
        default: ;
      endcase
    end
  end

  // A restart rewinds the walk before the current element is taken.
  always_comb begin
    cur_phase = in_restart ? 1'b0 : phase_r;
    cur_half  = in_restart ? 1'b0 : half_r;
    cur_face  = (in_restart || face_r > LAST_FACE) ? '0 : face_r;
    cur_row   = in_restart ? '0 : row_r;
    cur_col   = in_restart ? '0 : col_r;
    cur_base  = in_restart ? '0 : base_r;
  end

  always_comb begin
    unique case (cur_face[FACE_W-1:1])
      2'd0: begin
        cols = seg_u_r;
        rows = seg_v_r;
      end
      2'd1: begin
        cols = seg_v_r;
        rows = seg_w_r;
      end
      default: begin
        cols = seg_w_r;
        rows = seg_u_r;
      end
    endcase
  end

  assign st   = CNT_W'(cols) + CNT_W'(1);
  assign rt   = CNT_W'(rows) + CNT_W'(1);
  assign area = (2*CNT_W)'(st) * (2*CNT_W)'(rt);
  // Vertices run over the grid points, triangles over the quads.
  assign clim = cur_phase ? CNT_W'(cols) - CNT_W'(1) : CNT_W'(cols);
  assign rlim = cur_phase ? CNT_W'(rows) - CNT_W'(1) : CNT_W'(rows);

  always_comb begin
    phase_nxt = cur_phase;
    half_nxt  = 1'b0;
    face_nxt  = cur_face;
    row_nxt   = cur_row;
    col_nxt   = cur_col;
    base_nxt  = cur_base;
    wrap      = 1'b0;
    if (cur_phase && !cur_half) begin
      half_nxt = 1'b1;
    end else if (cur_col < clim) begin
      col_nxt = cur_col + CNT_W'(1);
    end else begin
      col_nxt = '0;
      if (cur_row < rlim) begin
        row_nxt = cur_row + CNT_W'(1);
      end else begin
        row_nxt = '0;
        if (cur_face < LAST_FACE) begin
          face_nxt = cur_face + FACE_W'(1);
          base_nxt = cur_base + BASE_W'(area);
        end else begin
          face_nxt  = '0;
          base_nxt  = '0;
          phase_nxt = !cur_phase;
          wrap      = cur_phase;
        end
      end
    end
  end

  assign q_push = in_push && !q_full;

  always_comb begin
    q_item.kind      = cur_phase ? KIND_TRIANGLE : KIND_VERTEX;
    q_item.face      = cur_face;
    q_item.col       = cur_col;
    q_item.row       = cur_row;
    q_item.cols      = cols;
    q_item.rows      = rows;
    q_item.half_quad = cur_half;
    q_item.base      = cur_base;
    q_item.last      = wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      half_r  <= 1'b0;
      face_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
      base_r  <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      face_r  <= face_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      base_r  <= base_nxt;
    end
  end

  `BMG_ASSERT_NOW(a_seg_nonzero, 1'b1, seg_u_r != '0 && seg_v_r != '0 && seg_w_r != '0, "segment count is zero")
  `BMG_ASSERT_NOW(a_face_range, 1'b1, face_r <= LAST_FACE, "face counter out of range")
  `BMG_ASSERT_NOW(a_half_in_tri, half_r, phase_r, "second half quad outside triangle phase")
  `BMG_ASSERT_NEXT(a_wrap_rewinds, q_push && wrap, face_r == '0 && base_r == '0 && !phase_r, "mesh wrap did not rewind the walk")

endmodule

[rtl/bmg_queue.sv]
// Two-entry queue of classified elements between front and back end.
// Depends on bmg_pkg for the element type.
module bmg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bmg_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output bmg_pkg::item_t pop_item,
  output logic           empty
);
  import bmg_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/bmg_back.sv]
// Back end: fraction dividers, index arithmetic and the result register.
// Depends on bmg_pkg and the assertion macros header.
`include "box_mesh_generator_unit_macros.svh"
module bmg_back #(
  parameter int FRAC_BITS = bmg_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  bmg_pkg::item_t                  q_item,
  output logic                            q_pop,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_kind,
  output logic signed [FRAC_BITS:0]       out_pos_x,
  output logic signed [FRAC_BITS:0]       out_pos_y,
  output logic signed [FRAC_BITS:0]       out_pos_z,
  output logic [bmg_pkg::FACE_W-1:0]      out_normal_code,
  output logic [FRAC_BITS:0]              out_tex_u,
  output logic [FRAC_BITS:0]              out_tex_v,
  output logic [bmg_pkg::BASE_W-1:0]      out_corner_a,
  output logic [bmg_pkg::BASE_W-1:0]      out_corner_b,
  output logic [bmg_pkg::BASE_W-1:0]      out_corner_c,
  output logic                            out_last
);
  import bmg_pkg::*;

  localparam int PW       = FRAC_BITS + 1;
  localparam int QW       = CNT_W + FRAC_BITS;
  localparam int STEPS    = (QW + 1) / 2;
  localparam int NUM_W    = 2 * STEPS;
  localparam int STEP_W   = $clog2(STEPS + 1);
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_DIV  = 2'd1;
  localparam logic [1:0] BK_TRI  = 2'd2;
  localparam logic [1:0] BK_DONE = 2'd3;

  typedef struct packed {
    logic [SEG_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [PW-1:0]    quot;
  } div_t;

  // Two restoring division steps; only the low PW quotient bits are kept.
  function automatic div_t div_steps(div_t d, logic [SEG_W-1:0] den);
    logic [SEG_W:0] t;
    div_t r;
    r = d;
    for (int k = 0; k < 2; k++) begin
      t = {r.rem, r.num[NUM_W-1]};
      r.num = r.num << 1;
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        r.quot = {r.quot[PW-2:0], 1'b1};
      end else begin
        r.quot = {r.quot[PW-2:0], 1'b0};
      end
      r.rem = t[SEG_W-1:0];
    end
    return r;
  endfunction

  logic [1:0]         state_r;
  item_t              item_r;
  div_t               div_a_r, div_b_r, div_a_nxt, div_b_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [2*CNT_W-1:0] prod_r;
  logic [BASE_W-1:0]  r0_r;
  logic               out_valid_r;
  logic               out_load;

  logic [PW-1:0]      pa, pb, side;
  logic [PW-1:0]      vx, vy, vz;
  logic [BASE_W-1:0]  stride, r1;
  logic [CNT_W-1:0]   q_stride;

  assign q_pop     = (state_r == BK_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_load  = (state_r == BK_DONE) && (!out_valid_r || out_pop);
  assign q_stride  = CNT_W'(q_item.cols) + CNT_W'(1);

  assign div_a_nxt = div_steps(div_a_r, item_r.cols);
  assign div_b_nxt = div_steps(div_b_r, item_r.rows);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      unique case (state_r)
        BK_IDLE: begin
          if (!q_empty) begin
            state_r <= (q_item.kind == KIND_VERTEX) ? BK_DIV : BK_TRI;
          end
        end
        BK_DIV: begin
          if (step_r == STEP_W'(1)) begin
            state_r <= BK_DONE;
          end
        end
        BK_TRI: state_r <= BK_DONE;
        BK_DONE: begin
          if (out_load) begin
            state_r <= BK_IDLE;
          end
        end
        default: state_r <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r       <= q_item;
      div_a_r.rem  <= '0;
      div_a_r.num  <= NUM_W'({q_item.col, {FRAC_BITS{1'b0}}});
      div_a_r.quot <= '0;
      div_b_r.rem  <= '0;
      div_b_r.num  <= NUM_W'({q_item.row, {FRAC_BITS{1'b0}}});
      div_b_r.quot <= '0;
      step_r       <= STEP_W'(STEPS);
      prod_r       <= (2*CNT_W)'(q_item.row) * (2*CNT_W)'(q_stride);
    end else if (state_r == BK_DIV) begin
      div_a_r <= div_a_nxt;
      div_b_r <= div_b_nxt;
      step_r  <= step_r - STEP_W'(1);
    end
    if (state_r == BK_TRI) begin
      r0_r <= item_r.base + BASE_W'(prod_r) + BASE_W'(item_r.col);
    end
  end

  // Vertex placement from the two fractions.
  always_comb begin
    pa   = div_a_r.quot - HALF;
    pb   = div_b_r.quot - HALF;
    side = item_r.face[0] ? HALF : PW'(0) - HALF;
    unique case (item_r.face[FACE_W-1:1])
      2'd0: begin
        vx = pa;
        vy = pb;
        vz = side;
      end
      2'd1: begin
        vx = side;
        vy = pa;
        vz = pb;
      end
      default: begin
        vx = pb;
        vy = side;
        vz = pa;
      end
    endcase
  end

  assign stride = BASE_W'(item_r.cols) + BASE_W'(1);
  assign r1     = r0_r + stride;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind        <= item_r.kind;
      out_normal_code <= item_r.face;
      if (item_r.kind == KIND_VERTEX) begin
        out_pos_x    <= vx;
        out_pos_y    <= vy;
        out_pos_z    <= vz;
        out_tex_u    <= div_a_r.quot;
        out_tex_v    <= div_b_r.quot;
        out_corner_a <= '0;
        out_corner_b <= '0;
        out_corner_c <= '0;
        out_last     <= 1'b0;
      end else begin
        out_pos_x    <= '0;
        out_pos_y    <= '0;
        out_pos_z    <= '0;
        out_tex_u    <= '0;
        out_tex_v    <= '0;
        out_corner_a <= r0_r;
        out_corner_b <= item_r.half_quad ? r1 + BASE_W'(1) : r1;
        out_corner_c <= item_r.half_quad ? r0_r + BASE_W'(1) : r1 + BASE_W'(1);
        out_last     <= item_r.last;
      end
    end
  end

  `BMG_ASSERT_NOW(a_div_vertex, state_r == BK_DIV, item_r.kind == KIND_VERTEX, "divider running on a triangle")
  `BMG_ASSERT_NOW(a_pop_idle, q_pop, state_r == BK_IDLE, "queue popped while busy")
  `BMG_ASSERT_NEXT(a_done_moves, out_load, out_valid_r && state_r == BK_IDLE, "finished element not transferred to output")

endmodule

[rtl/box_mesh_generator_unit.sv]
// Channel   Ports                                      Transfer when
// input     in_push, in_full, in_restart               in_push && !in_full
// result    out_pop, out_empty, out_kind .. out_last   out_pop && !out_empty
// config    cfg_we, cfg_index, cfg_data                cfg_we
//
// A vertex passes through the back end as the two fraction dividers retire two quotient
// bits a cycle; the result is then loaded into the output register.
// A triangle takes a multiply, an add and an output load, in that order.
// Unless the two-entry queue is full, the front end takes an element each cycle, so input and
// result sides stall independently. Reset is synchronous and active low; no clearing pass.
// Top level of the box mesh generator; depends on bmg_pkg, bmg_front, bmg_queue, bmg_back.
module box_mesh_generator_unit #(
  parameter int MAX_SEGMENTS = bmg_pkg::DEF_MAX_SEGMENTS,
  parameter int FRAC_BITS    = bmg_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmg_pkg::SEG_W-1:0]      cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_restart,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_kind,
  output logic signed [FRAC_BITS:0]      out_pos_x,
  output logic signed [FRAC_BITS:0]      out_pos_y,
  output logic signed [FRAC_BITS:0]      out_pos_z,
  output logic [bmg_pkg::FACE_W-1:0]     out_normal_code,
  output logic [FRAC_BITS:0]             out_tex_u,
  output logic [FRAC_BITS:0]             out_tex_v,
  output logic [bmg_pkg::BASE_W-1:0]     out_corner_a,
  output logic [bmg_pkg::BASE_W-1:0]     out_corner_b,
  output logic [bmg_pkg::BASE_W-1:0]     out_corner_c,
  output logic                           out_last
);
  import bmg_pkg::*;

  item_t fq_item, qb_item;
  logic  fq_push, q_full, q_empty, q_pop;

  assign in_full = q_full;

  bmg_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_push    (in_push),
    .in_restart (in_restart),
    .q_full     (q_full),
    .q_push     (fq_push),
    .q_item     (fq_item)
  );

  bmg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (qb_item),
    .empty     (q_empty)
  );

  bmg_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (qb_item),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_normal_code (out_normal_code),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_corner_a    (out_corner_a),
    .out_corner_b    (out_corner_b),
    .out_corner_c    (out_corner_c),
    .out_last        (out_last)
  );

endmodule

[bench/tb_top.sv]
// Self-checking testbench for box_mesh_generator_unit: random restart items, segment
// settings and stalls on both queues, each element checked against a predictor.
// Depends on bmg_pkg and the box_mesh_generator_unit RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmg_pkg::*;

  localparam int FB = DEF_FRAC_BITS;
  localparam int DIRECTED_ITEMS = 26;
  localparam int TOTAL_ITEMS = DIRECTED_ITEMS + 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT = 11;

  // Face pairs share a grid shape; bit 0 of the face code picks the positive side.
  localparam logic [1:0] GROUP_Z = 2'd0;
  localparam logic [1:0] GROUP_X = 2'd1;
  localparam logic [FB:0] HALF = {2'b01, {(FB-1){1'b0}}};

  typedef struct packed {
    logic              kind;
    logic [FB:0]       pos_x;
    logic [FB:0]       pos_y;
    logic [FB:0]       pos_z;
    logic [FACE_W-1:0] normal;
    logic [FB:0]       tex_u;
    logic [FB:0]       tex_v;
    logic [BASE_W-1:0] corner_a;
    logic [BASE_W-1:0] corner_b;
    logic [BASE_W-1:0] corner_c;
    logic              last_tri;
  } mesh_elem_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SEG_W-1:0]     cfg_data = '0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 in_restart = 1'b0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic                 out_kind;
  logic signed [FB:0]   out_pos_x, out_pos_y, out_pos_z;
  logic [FACE_W-1:0]    out_normal_code;
  logic [FB:0]          out_tex_u, out_tex_v;
  logic [BASE_W-1:0]    out_corner_a, out_corner_b, out_corner_c;
  logic                 out_last;

  // Predictor copy of the segment registers and of the mesh cursor.
  logic [SEG_W-1:0]  seg_u, seg_v, seg_w;
  logic              tri_phase;
  logic [FACE_W-1:0] cur_face;
  logic [CNT_W-1:0]  cur_row, cur_col;
  logic              second_half;
  logic [BASE_W-1:0] cur_base;

  mesh_elem_t expected_elems[$];
  logic       restart_queue[$];
  int         errors = 0;
  int         idle_pct = IDLE_PCT;
  int         cycle_count = 0;

  box_mesh_generator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_restart(in_restart),
    .out_empty(out_empty), .out_pop(out_pop), .out_kind(out_kind),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_normal_code(out_normal_code), .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .out_corner_a(out_corner_a), .out_corner_b(out_corner_b),
    .out_corner_c(out_corner_c), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void rewind_cursor();
    tri_phase = 1'b0;
    cur_face = '0;
    cur_row = '0;
    cur_col = '0;
    second_half = 1'b0;
    cur_base = '0;
  endfunction

  // Moves the cursor one element on; returns 1 when the whole mesh wraps.
  function automatic logic step_mesh_cursor(input int unsigned cols, input int unsigned rows);
    int unsigned col_lim, row_lim, area;
    if (tri_phase && !second_half) begin
      second_half = 1'b1;
      return 1'b0;
    end
    second_half = 1'b0;
    col_lim = tri_phase ? cols - 1 : cols;
    row_lim = tri_phase ? rows - 1 : rows;
    if (32'(cur_col) < col_lim) begin
      cur_col = cur_col + 1'b1;
      return 1'b0;
    end
    cur_col = '0;
    if (32'(cur_row) < row_lim) begin
      cur_row = cur_row + 1'b1;
      return 1'b0;
    end
    cur_row = '0;
    if (cur_face < LAST_FACE) begin
      area = (cols + 1) * (rows + 1);
      cur_base = cur_base + area[BASE_W-1:0];
      cur_face = cur_face + 1'b1;
      return 1'b0;
    end
    cur_face = '0;
    cur_base = '0;
    if (!tri_phase) begin
      tri_phase = 1'b1;
      return 1'b0;
    end
    tri_phase = 1'b0;
    return 1'b1;
  endfunction

  function automatic mesh_elem_t emit_mesh_element(input logic restart);
    mesh_elem_t  e;
    int unsigned cols, rows, a_full, b_full, stride, r0, r1, r0_next, r1_next;
    logic [FB:0] a, b, side, pa, pb;
    e = '0;
    if (restart)
      rewind_cursor();
    case (cur_face[2:1])
      GROUP_Z: begin
        cols = 32'(seg_u);
        rows = 32'(seg_v);
      end
      GROUP_X: begin
        cols = 32'(seg_v);
        rows = 32'(seg_w);
      end
      default: begin
        cols = 32'(seg_w);
        rows = 32'(seg_u);
      end
    endcase
    e.normal = cur_face;
    if (!tri_phase) begin
      // Counters may sit past a freshly lowered limit; the quotient is then simply masked.
      a_full = (int'(cur_col) << FB) / cols;
      b_full = (int'(cur_row) << FB) / rows;
      a = a_full[FB:0];
      b = b_full[FB:0];
      side = cur_face[0] ? HALF : -HALF;
      pa = a - HALF;
      pb = b - HALF;
      e.kind = KIND_VERTEX;
      case (cur_face[2:1])
        GROUP_Z: begin
          e.pos_x = pa;
          e.pos_y = pb;
          e.pos_z = side;
        end
        GROUP_X: begin
          e.pos_x = side;
          e.pos_y = pa;
          e.pos_z = pb;
        end
        default: begin
          e.pos_x = pb;
          e.pos_y = side;
          e.pos_z = pa;
        end
      endcase
      e.tex_u = a;
      e.tex_v = b;
      void'(step_mesh_cursor(cols, rows));
    end else begin
      stride = cols + 1;
      r0 = 32'(cur_base) + 32'(cur_row) * stride + 32'(cur_col);
      r1 = r0 + stride;
      r0_next = r0 + 1;
      r1_next = r1 + 1;
      e.kind = KIND_TRIANGLE;
      e.corner_a = r0[BASE_W-1:0];
      if (!second_half) begin
        e.corner_b = r1[BASE_W-1:0];
        e.corner_c = r1_next[BASE_W-1:0];
      end else begin
        e.corner_b = r1_next[BASE_W-1:0];
        e.corner_c = r0_next[BASE_W-1:0];
      end
      e.last_tri = step_mesh_cursor(cols, rows);
    end
    return e;
  endfunction

  task automatic check_field(input string field, input logic [BASE_W-1:0] want,
                             input logic [BASE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  task automatic write_segments(input logic [CFG_IDX_W-1:0] index, input logic [SEG_W-1:0] value);
    logic [SEG_W-1:0] stored;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    stored = (value == '0) ? 8'd1 : value;
    case (index)
      CFG_SEG_U: seg_u = stored;
      CFG_SEG_V: seg_v = stored;
      CFG_SEG_W: seg_w = stored;
      default: ;
    endcase
  endtask

  // Returns once nothing is queued, in flight or awaited.
  task automatic wait_idle();
    do
      @(posedge clk);
    while (restart_queue.size() != 0 || in_push || expected_elems.size() != 0);
  endtask

  // Input driver: one transfer per accepted push, fed from restart_queue.
  always @(posedge clk) begin
    logic next_push, next_restart;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_restart <= 1'b0;
    end else begin
      next_push = in_push;
      next_restart = in_restart;
      if (in_push && !in_full) begin
        expected_elems.push_back(emit_mesh_element(in_restart));
        next_push = 1'b0;
      end
      if (!next_push && restart_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_push = 1'b1;
        next_restart = restart_queue.pop_front();
      end
      in_push <= next_push;
      in_restart <= next_restart;
    end
  end

  // Result monitor: compares each transfer with the oldest expected element.
  always @(posedge clk) begin
    mesh_elem_t got, want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got = '{out_kind, out_pos_x, out_pos_y, out_pos_z, out_normal_code, out_tex_u,
                out_tex_v, out_corner_a, out_corner_b, out_corner_c, out_last};
        if (expected_elems.size() == 0) begin
          $display("%0t ns: unexpected element, expected none, actual kind %0d",
                   $time, out_kind);
          errors++;
        end else begin
          want = expected_elems.pop_front();
          check_field("kind", BASE_W'(want.kind), BASE_W'(got.kind));
          check_field("pos_x", BASE_W'(want.pos_x), BASE_W'(got.pos_x));
          check_field("pos_y", BASE_W'(want.pos_y), BASE_W'(got.pos_y));
          check_field("pos_z", BASE_W'(want.pos_z), BASE_W'(got.pos_z));
          check_field("normal_code", BASE_W'(want.normal), BASE_W'(got.normal));
          check_field("tex_u", BASE_W'(want.tex_u), BASE_W'(got.tex_u));
          check_field("tex_v", BASE_W'(want.tex_v), BASE_W'(got.tex_v));
          check_field("corner_a", want.corner_a, got.corner_a);
          check_field("corner_b", want.corner_b, got.corner_b);
          check_field("corner_c", want.corner_c, got.corner_c);
          check_field("last", BASE_W'(want.last_tri), BASE_W'(got.last_tri));
        end
      end
      out_pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int queued, phase_no, len;
    logic [SEG_W-1:0] u, v, w;
    logic wide;
    seg_u = 8'd1;
    seg_v = 8'd1;
    seg_w = 8'd1;
    rewind_cursor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: at the reset sizes, restart, walk all 24 vertices into the first
    // triangle, then restart in the middle of the mesh.
    restart_queue.push_back(1'b1);
    repeat (24) restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b1);
    queued = DIRECTED_ITEMS;

    phase_no = 0;
    while (queued < TOTAL_ITEMS) begin
      // Each new setting waits until every queued element has come back.
      wait_idle();
      idle_pct = (phase_no == 3 || phase_no == 4) ? 0 : IDLE_PCT;
      wide = ($urandom_range(7) == 0);
      if (phase_no == 0) begin
        u = 8'd255;
        v = 8'd0;
        w = 8'd2;
        wide = 1'b1;
      end else if (phase_no == 1 || (wide && $urandom_range(3) == 0)) begin
        u = 8'd255;
        v = 8'd255;
        w = 8'd255;
      end else if (wide) begin
        u = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 3));
        v = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 3));
        w = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 3));
      end else begin
        u = 8'($urandom_range(0, 3));
        v = 8'($urandom_range(0, 3));
        w = 8'($urandom_range(0, 3));
      end
      write_segments(CFG_SEG_U, u);
      write_segments(CFG_SEG_V, v);
      write_segments(CFG_SEG_W, w);
      @(posedge clk);
      cfg_we <= 1'b0;

      // Phases mostly run on from where the last one stopped, so a new size can
      // land on counters that are already past it.
      if (phase_no == 1)
        len = 60;
      else
        len = wide ? $urandom_range(150, 350) : $urandom_range(20, 150);
      if (len > TOTAL_ITEMS - queued)
        len = TOTAL_ITEMS - queued;
      restart_queue.push_back($urandom_range(2) == 0);
      repeat (len - 1) restart_queue.push_back($urandom_range(39) == 0);
      queued += len;
      phase_no++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_elems.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
